// ===== design/tftp_pkg.sv =====
// package for the tftp write receiver: payload structs, protocol constants
// no dependencies
package tftp_pkg;

  localparam int unsigned AddrBitsDefault   = 24;
  localparam int unsigned BlockBytesDefault = 512;

  localparam logic [15:0] ListenPortReset = 16'd69;
  localparam logic [15:0] ProtoUdp        = 16'd17;
  localparam logic [15:0] HdrTftp         = 16'd12;
  localparam logic [15:0] OpRead          = 16'd1;
  localparam logic [15:0] OpWrite         = 16'd2;
  localparam logic [15:0] OpData          = 16'd3;
  localparam logic [3:0]  ModeName        = 4'd0;
  localparam logic [3:0]  ModeDone        = 4'd7;
  localparam logic [3:0]  ModeFail        = 4'd8;

  typedef enum logic [1:0] {
    ReplyNone  = 2'd0,
    ReplyAck   = 2'd1,
    ReplyError = 2'd2
  } reply_kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } in_item_t;

  typedef struct packed {
    logic        wr_valid;
    logic [23:0] wr_addr;
    logic [7:0]  wr_data;
    logic        packet_done;
    logic [1:0]  reply_kind;
    logic [15:0] reply_block;
    logic [15:0] reply_port;
    logic        checksum_bad;
    logic        file_ready;
    logic [23:0] file_bytes;
    logic [15:0] file_blocks;
    logic [31:0] error_count;
  } out_item_t;

  // expected byte of "octet" at match position 1..5
  function automatic logic [7:0] octet_char(logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd1:    c = 8'h6f;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tftp_write_receiver_core.sv =====
// tftp write receiver: udp checksum check, tftp request and data handling
// depends on tftp_pkg
//
// Usage: one UDP segment byte per input item on in_valid_i/in_ready_o, header
// first, with the packet's IP addresses alongside and last_byte on the final
// byte. Every input item yields exactly one result item on
// out_valid_o/out_ready_i carrying a possible file write, the file totals
// after the update and, on the last byte, the verdict (reply kind, block,
// port, checksum result).
// Each result is registered. Throughput: one item per cycle while the skid
// stage is free; the segment state updates in one pass per byte, and the final
// checksum fold is a single 3-stage carry-wrap add on the last byte.
// A single result register with a skid stage lets the input keep flowing
// while a result waits; when the receiver stalls with both full, in_ready_o
// drops until a result is taken.
// Reset clears all segment and file state and sets listen port to 69.
// cfg_we_i writes listen port at any edge; do so only while idle.
module tftp_write_receiver_core #(
  parameter int unsigned ADDR_BITS   = tftp_pkg::AddrBitsDefault,
  parameter int unsigned BLOCK_BYTES = tftp_pkg::BlockBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tftp_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tftp_pkg::out_item_t out_data_o
);

  localparam logic [23:0] OffLimit = (ADDR_BITS >= 24) ? 24'hFFFFFF
                                   : 24'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [15:0] BlkBytes = 16'(BLOCK_BYTES);

  logic [15:0] listen_q;
  logic [15:0] idx_q, idx_d;
  logic [31:0] csum_q, csum_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] cport_q, cport_d, sport_q, sport_d, slen_q, slen_d;
  logic [15:0] op_q, op_d, blk_q, blk_d;
  logic [3:0]  mode_q, mode_d;
  logic [15:0] lastblk_q, lastblk_d, bcnt_q, bcnt_d;
  logic [23:0] off_q, off_d;
  logic        rdy_q, rdy_d;
  logic [31:0] fail_q, fail_d;

  tftp_pkg::out_item_t res;
  tftp_pkg::out_item_t main_q, skid_q;
  logic main_v_q, skid_v_q;

  logic accept;
  assign in_ready_o = !skid_v_q;
  assign accept = in_valid_i && in_ready_o;

  logic [7:0]  b;
  logic        used;
  logic [15:0] plen, pidx;
  logic [24:0] waddr, tsum;
  logic [18:0] s1;
  logic [16:0] s2;
  logic [15:0] s3;
  logic [31:0] sip, dip;
  logic        bad, port_ok;

  always_comb begin
    b = in_data_i.data_byte;
    sip = in_data_i.src_ip;
    dip = in_data_i.dst_ip;
    idx_d = idx_q; csum_d = csum_q; hold_d = hold_q; cport_d = cport_q;
    sport_d = sport_q; slen_d = slen_q; op_d = op_q; blk_d = blk_q;
    mode_d = mode_q; lastblk_d = lastblk_q; bcnt_d = bcnt_q; off_d = off_q;
    rdy_d = rdy_q; fail_d = fail_q;
    res = '0;
    used = (idx_q < 16'd6) || (idx_q < slen_q);
    plen = (slen_q >= tftp_pkg::HdrTftp) ? slen_q - tftp_pkg::HdrTftp : 16'd0;
    if (plen > BlkBytes) plen = BlkBytes;
    pidx = idx_q - tftp_pkg::HdrTftp;
    waddr = {1'b0, off_q} + {9'd0, pidx};
    if (used) begin
      csum_d = csum_q + (idx_q[0] ? {24'd0, b} : {16'd0, b, 8'd0});
      unique case (idx_q)
        16'd0, 16'd2, 16'd4, 16'd8, 16'd10: hold_d = b;
        16'd1:  cport_d = {hold_q, b};
        16'd3:  sport_d = {hold_q, b};
        16'd5:  slen_d = {hold_q, b};
        16'd9:  op_d = {hold_q, b};
        16'd11: blk_d = {hold_q, b};
        default: ;
      endcase
      if (idx_q >= 16'd10) begin
        if (mode_q == tftp_pkg::ModeName) begin
          if (b == 8'd0) mode_d = 4'd1;
        end else if (mode_q >= 4'd1 && mode_q <= 4'd5) begin
          mode_d = (b == tftp_pkg::octet_char(mode_q[2:0])) ? mode_q + 4'd1
                                                             : tftp_pkg::ModeFail;
        end else if (mode_q == 4'd6) begin
          mode_d = (b == 8'd0) ? tftp_pkg::ModeDone : tftp_pkg::ModeFail;
        end
      end
      if (idx_q >= tftp_pkg::HdrTftp && sport_q == listen_q &&
          op_q == tftp_pkg::OpData && blk_q > lastblk_q && pidx < plen &&
          waddr <= {1'b0, OffLimit}) begin
        res.wr_valid = 1'b1;
        res.wr_addr  = waddr[23:0];
        res.wr_data  = b;
      end
    end
    if (idx_q != 16'hFFFF) idx_d = idx_q + 16'd1;

    // checksum fold, using the segment state after this byte
    s1 = 19'(csum_d[31:16]) + 19'(csum_d[15:0]) + 19'(sip[31:16]) + 19'(sip[15:0])
       + 19'(dip[31:16]) + 19'(dip[15:0]) + 19'(tftp_pkg::ProtoUdp) + 19'(slen_d);
    s2 = 17'(s1[15:0]) + 17'(s1[18:16]);
    s3 = s2[15:0] + 16'(s2[16]);
    bad = (s3 != 16'hFFFF);
    port_ok = (sport_d == listen_q);
    tsum = {1'b0, off_q} + {9'd0, plen};

    if (in_data_i.last_byte) begin
      res.packet_done  = 1'b1;
      res.checksum_bad = bad;
      res.reply_port   = cport_d;
      if (bad) fail_d = fail_q + 32'd1;
      if (port_ok && !bad) begin
        unique case (op_d)
          tftp_pkg::OpRead: begin
            res.reply_kind = tftp_pkg::ReplyError;
          end
          tftp_pkg::OpWrite: begin
            lastblk_d = '0; off_d = '0; bcnt_d = '0; rdy_d = 1'b0;
            res.reply_kind = (mode_d == tftp_pkg::ModeDone) ? tftp_pkg::ReplyAck
                                                            : tftp_pkg::ReplyError;
          end
          tftp_pkg::OpData: begin
            res.reply_kind  = tftp_pkg::ReplyAck;
            res.reply_block = blk_d;
            if (blk_d > lastblk_q) begin
              lastblk_d = blk_d;
              off_d = (tsum > {1'b0, OffLimit}) ? OffLimit : tsum[23:0];
              if (bcnt_q != 16'hFFFF) bcnt_d = bcnt_q + 16'd1;
              if (plen < BlkBytes) rdy_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      idx_d = '0; csum_d = '0; hold_d = '0; cport_d = '0; sport_d = '0;
      slen_d = '0; op_d = '0; blk_d = '0; mode_d = tftp_pkg::ModeName;
    end
    res.file_ready   = rdy_d;
    res.file_bytes   = off_d;
    res.file_blocks  = bcnt_d;
    res.error_count  = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q <= tftp_pkg::ListenPortReset;
      idx_q <= '0; csum_q <= '0; hold_q <= '0; cport_q <= '0; sport_q <= '0;
      slen_q <= '0; op_q <= '0; blk_q <= '0; mode_q <= tftp_pkg::ModeName;
      lastblk_q <= '0; bcnt_q <= '0; off_q <= '0; rdy_q <= 1'b0; fail_q <= '0;
    end else begin
      if (cfg_we_i) listen_q <= cfg_wdata_i;
      if (accept) begin
        idx_q <= idx_d; csum_q <= csum_d; hold_q <= hold_d; cport_q <= cport_d;
        sport_q <= sport_d; slen_q <= slen_d; op_q <= op_d; blk_q <= blk_d;
        mode_q <= mode_d; lastblk_q <= lastblk_d; bcnt_q <= bcnt_d;
        off_q <= off_d; rdy_q <= rdy_d; fail_q <= fail_d;
      end
    end
  end

  // output register plus skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!main_v_q || out_ready_i) begin
        if (skid_v_q) begin
          main_v_q <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          main_v_q <= accept;
        end
      end else if (accept) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || out_ready_i) begin
      if (skid_v_q) main_q <= skid_q;
      else if (accept) main_q <= res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q) else $error("skid full while output empty");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !accept) else $error("accept with skid full");
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= tftp_pkg::ModeFail) else $error("mode tracker out of range");
endmodule
